/* rtl/core/euv_pkg.sv */
// ----------------------------------------------------------------------------
// euv_pkg
// Shared widths, constants, the arctangent table and the word types of the
// Euler vector rotator.
// ----------------------------------------------------------------------------
package euv_pkg;

	localparam int VecWidth    = 32;
	localparam int AngWidth    = 16;
	localparam int CordicSteps = 24;
	// reduction (2) + rotation steps + sign fix (1)
	localparam int CordicStages = CordicSteps + 3;

	// Q2.30 constants
	localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
	localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
	localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
	localparam logic signed [32:0] GainInv   = 33'sd652032874;

	typedef struct packed {
		logic signed [VecWidth-1:0] vec_x;
		logic signed [VecWidth-1:0] vec_y;
		logic signed [VecWidth-1:0] vec_z;
		logic signed [AngWidth-1:0] roll_angle;
		logic signed [AngWidth-1:0] pitch_angle;
		logic signed [AngWidth-1:0] yaw_angle;
	} in_word_t;

	typedef struct packed {
		logic signed [VecWidth-1:0] out_x;
		logic signed [VecWidth-1:0] out_y;
		logic signed [VecWidth-1:0] out_z;
		logic                       overflow;
	} out_word_t;

	// truncated arctangent of 2^-i in Q2.30
	function automatic logic signed [33:0] atan_q30(input int unsigned i);
		logic signed [33:0] r;
		unique case (i)
			0:  r = 34'sh03243F6A8;
			1:  r = 34'sh01DAC6705;
			2:  r = 34'sh00FADBAFC;
			3:  r = 34'sh007F56EA6;
			4:  r = 34'sh003FEAB76;
			5:  r = 34'sh001FFD55B;
			6:  r = 34'sh000FFFAAA;
			7:  r = 34'sh0007FFF55;
			8:  r = 34'sh0003FFFEA;
			9:  r = 34'sh0001FFFFD;
			10: r = 34'sh0000FFFFF;
			11: r = 34'sh00007FFFF;
			12: r = 34'sh00003FFFF;
			13: r = 34'sh00001FFFF;
			14: r = 34'sh00000FFFF;
			15: r = 34'sh000007FFF;
			16: r = 34'sh000003FFF;
			17: r = 34'sh000001FFF;
			18: r = 34'sh000000FFF;
			19: r = 34'sh0000007FF;
			20: r = 34'sh0000003FF;
			21: r = 34'sh0000001FF;
			22: r = 34'sh0000000FF;
			23: r = 34'sh00000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/euv_cordic.sv */
// ----------------------------------------------------------------------------
// euv_cordic
// Pipelined sine and cosine of one Q3.12 angle: range reduction over two
// stages, one rotation step per stage, then the half-turn sign fix.
// ----------------------------------------------------------------------------
module euv_cordic
	import euv_pkg::*;
(
	input  logic                            clk,
	input  logic [CordicStages-1:0]         en,
	input  logic signed [AngWidth-1:0]      angle,
	output logic signed [32:0]              sin_val,
	output logic signed [32:0]              cos_val
);

	localparam int AngShift = 34 - AngWidth;

	logic signed [35:0] ang_q30;
	logic signed [35:0] red_a;
	logic signed [35:0] half_in;
	logic signed [32:0] a_s1;
	logic signed [33:0] a_s2;
	logic               flip_s2;

	logic signed [32:0] cx_s [CordicSteps+1];
	logic signed [32:0] cy_s [CordicSteps+1];
	logic signed [33:0] ca_s [CordicSteps+1];
	logic               cf_s [CordicSteps+1];

	logic signed [32:0] sin_sf;
	logic signed [32:0] cos_sf;

	// full-turn reduction
	assign ang_q30 = 36'(angle) <<< AngShift;

	always_comb begin
		if (ang_q30 > PiQ30) begin
			red_a = ang_q30 - TwoPiQ30;
		end else if (ang_q30 < -PiQ30) begin
			red_a = ang_q30 + TwoPiQ30;
		end else begin
			red_a = ang_q30;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1 <= red_a[32:0];
		end
	end

	// half-turn reduction with sign flag
	assign half_in = 36'(a_s1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			if (half_in > HalfPiQ30) begin
				a_s2    <= 34'(half_in - PiQ30);
				flip_s2 <= 1'b1;
			end else if (half_in < -HalfPiQ30) begin
				a_s2    <= 34'(half_in + PiQ30);
				flip_s2 <= 1'b1;
			end else begin
				a_s2    <= half_in[33:0];
				flip_s2 <= 1'b0;
			end
		end
	end

	assign cx_s[0] = GainInv;
	assign cy_s[0] = '0;
	assign ca_s[0] = a_s2;
	assign cf_s[0] = flip_s2;

	// one rotation step per stage
	for (genvar i = 0; i < CordicSteps; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en[i+2]) begin
				if (ca_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					ca_s[i+1] <= ca_s[i] - atan_q30(i);
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					ca_s[i+1] <= ca_s[i] + atan_q30(i);
				end
				cf_s[i+1] <= cf_s[i];
			end
		end
	end

	// undo the half-turn
	always_ff @(posedge clk) begin
		if (en[CordicStages-1]) begin
			cos_sf <= cf_s[CordicSteps] ? -cx_s[CordicSteps] : cx_s[CordicSteps];
			sin_sf <= cf_s[CordicSteps] ? -cy_s[CordicSteps] : cy_s[CordicSteps];
		end
	end

	assign sin_val = sin_sf;
	assign cos_val = cos_sf;

	logic unused_a;
	assign unused_a = ^ca_s[CordicSteps];

endmodule

/* rtl/core/euler_vector_rotator.sv */
// ----------------------------------------------------------------------------
// euler_vector_rotator
// Rotates a Q16.16 vector by Z-Y-X Euler angles: CORDIC sine and cosine,
// rotation matrix in Q2.30, row products rounded and saturated.
// ----------------------------------------------------------------------------
//  channel   direction  word        handshake
//  in        input      in_word     in_valid / in_ready
//  out       output     out_word    out_valid / out_ready
//
//  one word accepted per cycle when nothing stalls
//  depth: reduction, 24 CORDIC steps one per stage, sign fix, matrix stages
//  each stage holds its word while the next one is full and not moving
//  arst_n clears only the stage valid bits
// ----------------------------------------------------------------------------
module euler_vector_rotator
	import euv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	localparam int StM1  = CordicStages;
	localparam int StM2  = StM1 + 1;
	localparam int StM3  = StM1 + 2;
	localparam int StD   = StM1 + 3;
	localparam int StE   = StM1 + 4;
	localparam int StF   = StM1 + 5;
	localparam int StG   = StM1 + 6;
	localparam int NumSt = StG + 1;
	localparam int HiW   = VecWidth - 15;
	localparam int TotW  = VecWidth + 38;
	localparam int ResW  = TotW - 30;
	localparam logic signed [TotW-1:0] HalfLsb = TotW'(64'sd536870912);

	function automatic logic signed [33:0] mul_q30(
		input logic signed [33:0] a,
		input logic signed [33:0] b
	);
		logic signed [67:0] p;
		p = (68'(a) * 68'(b)) + 68'sd536870912;
		return 34'(p >>> 30);
	endfunction

	logic [NumSt-1:0] vld_q;
	logic [NumSt:0]   rdy;

	// ready walks back from the output
	assign rdy[NumSt] = out_ready;
	for (genvar k = 0; k < NumSt; k++) begin : g_rdy
		assign rdy[k] = ~vld_q[k] | rdy[k+1];
	end

	// valid bits follow the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NumSt; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NumSt-1];

	// sine and cosine units
	logic signed [32:0] sg, cg, sb, cb, sa, ca;

	euv_cordic u_roll (
		.clk(clk), .en(rdy[CordicStages-1:0]), .angle(in_word.roll_angle),
		.sin_val(sg), .cos_val(cg)
	);
	euv_cordic u_pitch (
		.clk(clk), .en(rdy[CordicStages-1:0]), .angle(in_word.pitch_angle),
		.sin_val(sb), .cos_val(cb)
	);
	euv_cordic u_yaw (
		.clk(clk), .en(rdy[CordicStages-1:0]), .angle(in_word.yaw_angle),
		.sin_val(sa), .cos_val(ca)
	);

	// vector delay line up to the row products
	logic signed [VecWidth-1:0] vec_s [StD][3];

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			vec_s[0][0] <= in_word.vec_x;
			vec_s[0][1] <= in_word.vec_y;
			vec_s[0][2] <= in_word.vec_z;
		end
		for (int k = 1; k < StD; k++) begin
			if (rdy[k]) begin
				vec_s[k] <= vec_s[k-1];
			end
		end
	end

	// first products
	logic signed [33:0] casb_s1, sasb_s1, m00_s1, m10_s1, m21_s1, m22_s1;
	logic signed [33:0] sacg_s1, sasg_s1, cacg_s1, casg_s1, sg_s1, cg_s1, sb_s1;

	always_ff @(posedge clk) begin
		if (rdy[StM1]) begin
			casb_s1 <= mul_q30(34'(ca), 34'(sb));
			sasb_s1 <= mul_q30(34'(sa), 34'(sb));
			m00_s1  <= mul_q30(34'(ca), 34'(cb));
			m10_s1  <= mul_q30(34'(sa), 34'(cb));
			m21_s1  <= mul_q30(34'(cb), 34'(sg));
			m22_s1  <= mul_q30(34'(cb), 34'(cg));
			sacg_s1 <= mul_q30(34'(sa), 34'(cg));
			sasg_s1 <= mul_q30(34'(sa), 34'(sg));
			cacg_s1 <= mul_q30(34'(ca), 34'(cg));
			casg_s1 <= mul_q30(34'(ca), 34'(sg));
			sg_s1   <= 34'(sg);
			cg_s1   <= 34'(cg);
			sb_s1   <= 34'(sb);
		end
	end

	// triple products
	logic signed [33:0] t1_s2, t2_s2, t3_s2, t4_s2;
	logic signed [33:0] m00_s2, m10_s2, m21_s2, m22_s2;
	logic signed [33:0] sacg_s2, sasg_s2, cacg_s2, casg_s2, sb_s2;

	always_ff @(posedge clk) begin
		if (rdy[StM2]) begin
			t1_s2   <= mul_q30(casb_s1, sg_s1);
			t2_s2   <= mul_q30(casb_s1, cg_s1);
			t3_s2   <= mul_q30(sasb_s1, sg_s1);
			t4_s2   <= mul_q30(sasb_s1, cg_s1);
			m00_s2  <= m00_s1;
			m10_s2  <= m10_s1;
			m21_s2  <= m21_s1;
			m22_s2  <= m22_s1;
			sacg_s2 <= sacg_s1;
			sasg_s2 <= sasg_s1;
			cacg_s2 <= cacg_s1;
			casg_s2 <= casg_s1;
			sb_s2   <= sb_s1;
		end
	end

	// matrix entries
	logic signed [33:0] mat_s3 [3][3];

	always_ff @(posedge clk) begin
		if (rdy[StM3]) begin
			mat_s3[0][0] <= m00_s2;
			mat_s3[0][1] <= t1_s2 - sacg_s2;
			mat_s3[0][2] <= t2_s2 + sasg_s2;
			mat_s3[1][0] <= m10_s2;
			mat_s3[1][1] <= t3_s2 + cacg_s2;
			mat_s3[1][2] <= t4_s2 - casg_s2;
			mat_s3[2][0] <= -sb_s2;
			mat_s3[2][1] <= m21_s2;
			mat_s3[2][2] <= m22_s2;
		end
	end

	// split each component into a high part and 16 low bits
	logic signed [VecWidth-1:0] vsh [3];
	logic signed [HiW-1:0]      vhi [3];
	logic signed [16:0]         vlo [3];

	for (genvar c = 0; c < 3; c++) begin : g_split
		assign vsh[c] = vec_s[StD-1][c] >>> 16;
		assign vhi[c] = vsh[c][HiW-1:0];
		assign vlo[c] = {1'b0, vec_s[StD-1][c][15:0]};
	end

	// row products
	logic signed [HiW+33:0] ph_s4 [3][3];
	logic signed [50:0]     pl_s4 [3][3];

	always_ff @(posedge clk) begin
		if (rdy[StD]) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					ph_s4[r][c] <= (HiW+34)'(mat_s3[r][c]) * (HiW+34)'(vhi[c]);
					pl_s4[r][c] <= 51'(mat_s3[r][c]) * 51'(vlo[c]);
				end
			end
		end
	end

	// row sums
	logic signed [HiW+35:0] hs_s5 [3];
	logic signed [52:0]     ls_s5 [3];

	always_ff @(posedge clk) begin
		if (rdy[StE]) begin
			for (int r = 0; r < 3; r++) begin
				hs_s5[r] <= (HiW+36)'(ph_s4[r][0]) + (HiW+36)'(ph_s4[r][1])
					+ (HiW+36)'(ph_s4[r][2]);
				ls_s5[r] <= 53'(pl_s4[r][0]) + 53'(pl_s4[r][1]) + 53'(pl_s4[r][2]);
			end
		end
	end

	// recombine and round half up
	logic signed [TotW-1:0] tot [3];
	logic signed [ResW-1:0] res_s6 [3];

	for (genvar r = 0; r < 3; r++) begin : g_tot
		assign tot[r] = (TotW'(hs_s5[r]) <<< 16) + TotW'(ls_s5[r]) + HalfLsb;
	end

	always_ff @(posedge clk) begin
		if (rdy[StF]) begin
			for (int r = 0; r < 3; r++) begin
				res_s6[r] <= ResW'(tot[r] >>> 30);
			end
		end
	end

	// saturate to the vector width
	logic [2:0]                 sat;
	logic signed [VecWidth-1:0] clip [3];
	localparam logic signed [VecWidth-1:0] VecMax = {1'b0, {(VecWidth-1){1'b1}}};
	localparam logic signed [VecWidth-1:0] VecMin = {1'b1, {(VecWidth-1){1'b0}}};

	for (genvar r = 0; r < 3; r++) begin : g_sat
		assign sat[r] = ~((&res_s6[r][ResW-1:VecWidth-1]) | ~(|res_s6[r][ResW-1:VecWidth-1]));
		assign clip[r] = sat[r] ? (res_s6[r][ResW-1] ? VecMin : VecMax)
			: res_s6[r][VecWidth-1:0];
	end

	out_word_t out_s7;

	always_ff @(posedge clk) begin
		if (rdy[StG]) begin
			out_s7.out_x    <= clip[0];
			out_s7.out_y    <= clip[1];
			out_s7.out_z    <= clip[2];
			out_s7.overflow <= |sat;
		end
	end

	assign out_word = out_s7;

	// checks
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("empty output stage but input stalled");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready) else $error("output taken but input stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0]) else $error("accepted word not in first stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[StF] && !rdy[StG] |=> vld_q[StF]) else $error("stalled word dropped");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives random and corner-case vectors and Euler angles into the rotator,
// predicts each rotated vector with an independent CORDIC and matrix model,
// and compares every output word in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top
	import euv_pkg::*;
;

	localparam int Latency  = 34;
	localparam int WdLimit  = 20000;
	localparam logic signed [63:0] RoundHalf = 64'sd536870912;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_word;

	out_word_t rotated_q[$];
	int        errors;
	int        idle_cycles;
	bit        hold_out;

	euler_vector_rotator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// arithmetic shift right, floor
	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan_entry(int i);
		longint t [CordicSteps] = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
			64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
			64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
			64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
			64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
		return t[i];
	endfunction

	// sine and cosine of one Q3.12 angle in Q2.30
	function automatic void angle_sin_cos(input logic signed [AngWidth-1:0] ang,
			output longint s, output longint c);
		longint a, x, y, nx;
		bit     flip;
		a = longint'(ang) * (64'sd1 <<< (30 - (AngWidth - 4)));
		x = 652032874;
		y = 0;
		flip = 1'b0;
		if (a > 64'sd3373259426) a -= 64'sd6746518852;
		else if (a < -64'sd3373259426) a += 64'sd6746518852;
		if (a > 64'sd1686629713) begin
			a -= 64'sd3373259426;
			flip = 1'b1;
		end else if (a < -64'sd1686629713) begin
			a += 64'sd3373259426;
			flip = 1'b1;
		end
		for (int i = 0; i < CordicSteps; i++) begin
			if (a >= 0) begin
				nx = x - shr_floor(y, i);
				y  = y + shr_floor(x, i);
				a -= atan_entry(i);
			end else begin
				nx = x + shr_floor(y, i);
				y  = y - shr_floor(x, i);
				a += atan_entry(i);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		return (a * b + RoundHalf) >>> 30;
	endfunction

	// one row of the matrix times the vector, exact with 128-bit sum, then rounded and saturated
	function automatic logic signed [VecWidth-1:0] row_sat(longint m0, longint m1,
			longint m2, logic signed [VecWidth-1:0] v0, logic signed [VecWidth-1:0] v1,
			logic signed [VecWidth-1:0] v2, inout bit ovf);
		logic signed [127:0] acc;
		logic signed [127:0] hi_lim, lo_lim;
		acc = 128'(signed'(m0)) * 128'(signed'(v0)) + 128'(signed'(m1)) * 128'(signed'(v1))
			+ 128'(signed'(m2)) * 128'(signed'(v2)) + 128'(signed'(RoundHalf));
		acc = acc >>> 30;
		hi_lim = (128'sd1 <<< (VecWidth - 1)) - 1;
		lo_lim = -hi_lim - 1;
		if (acc > hi_lim) begin
			ovf = 1'b1;
			return hi_lim[VecWidth-1:0];
		end
		if (acc < lo_lim) begin
			ovf = 1'b1;
			return lo_lim[VecWidth-1:0];
		end
		return acc[VecWidth-1:0];
	endfunction

	function automatic out_word_t rotate_vector(in_word_t w);
		longint    sg, cg, sb, cb, sa, ca, casb, sasb;
		longint    m [3][3];
		bit        ovf;
		out_word_t r;
		angle_sin_cos(w.roll_angle, sg, cg);
		angle_sin_cos(w.pitch_angle, sb, cb);
		angle_sin_cos(w.yaw_angle, sa, ca);
		casb = q30_mul(ca, sb);
		sasb = q30_mul(sa, sb);
		m[0][0] = q30_mul(ca, cb);
		m[0][1] = q30_mul(casb, sg) - q30_mul(sa, cg);
		m[0][2] = q30_mul(casb, cg) + q30_mul(sa, sg);
		m[1][0] = q30_mul(sa, cb);
		m[1][1] = q30_mul(sasb, sg) + q30_mul(ca, cg);
		m[1][2] = q30_mul(sasb, cg) - q30_mul(ca, sg);
		m[2][0] = -sb;
		m[2][1] = q30_mul(cb, sg);
		m[2][2] = q30_mul(cb, cg);
		ovf = 1'b0;
		r.out_x = row_sat(m[0][0], m[0][1], m[0][2], w.vec_x, w.vec_y, w.vec_z, ovf);
		r.out_y = row_sat(m[1][0], m[1][1], m[1][2], w.vec_x, w.vec_y, w.vec_z, ovf);
		r.out_z = row_sat(m[2][0], m[2][1], m[2][2], w.vec_x, w.vec_y, w.vec_z, ovf);
		r.overflow = ovf;
		return r;
	endfunction

	function automatic logic signed [31:0] rand_vec_comp(bit wide);
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return wide ? $urandom : 32'(signed'($urandom_range(0, 32'h1FFFFF)) - 32'sh100000);
			2: return 32'(signed'($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
			default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 3)
				: 32'sh80000000 + $urandom_range(0, 3);
		endcase
	endfunction

	function automatic in_word_t random_word(bit wide);
		in_word_t w;
		w.vec_x = rand_vec_comp(wide);
		w.vec_y = rand_vec_comp(wide);
		w.vec_z = rand_vec_comp(wide);
		w.roll_angle  = AngWidth'($urandom);
		w.pitch_angle = AngWidth'($urandom);
		w.yaw_angle   = AngWidth'($urandom);
		return w;
	endfunction

	function automatic in_word_t make_word(int x, int y, int z, int r, int p, int yw);
		in_word_t w;
		w.vec_x = x;
		w.vec_y = y;
		w.vec_z = z;
		w.roll_angle  = r[AngWidth-1:0];
		w.pitch_angle = p[AngWidth-1:0];
		w.yaw_angle   = yw[AngWidth-1:0];
		return w;
	endfunction

	// send one word after a given or random gap, valid stays high when no gap follows
	task automatic send_word(in_word_t w, int gap = -1);
		int n;
		n = (gap < 0) ? $urandom_range(0, 9) : gap;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_word  <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		rotated_q.push_back(rotate_vector(w));
		@(negedge clk);
	endtask

	// back to back, valid held high across words
	task automatic send_burst(int count);
		in_word_t w;
		for (int k = 0; k < count; k++) begin
			w = random_word(1'b0);
			in_word  <= w;
			in_valid <= 1'b1;
			do @(posedge clk); while (!in_ready);
			rotated_q.push_back(rotate_vector(w));
			@(negedge clk);
		end
	endtask

	// stop offering and wait for every expected word
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (rotated_q.size() != 0) @(negedge clk);
	endtask

	// receiver stall, drawn at random, plus a forced long hold-off
	initial begin
		int stall_n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_out) out_ready <= 1'b0;
			else begin
				stall_n = $urandom_range(0, 9);
				if (stall_n == 0) out_ready <= 1'b1;
				else begin
					out_ready <= 1'b0;
					repeat (stall_n - 1) @(negedge clk);
				end
			end
		end
	end

	// output check
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (rotated_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected output word %h", $time, out_word);
			end else begin
				want = rotated_q.pop_front();
				if (out_word.out_x !== want.out_x) begin
					errors++;
					$display("%0t: out_x expected %h actual %h", $time, want.out_x, out_word.out_x);
				end
				if (out_word.out_y !== want.out_y) begin
					errors++;
					$display("%0t: out_y expected %h actual %h", $time, want.out_y, out_word.out_y);
				end
				if (out_word.out_z !== want.out_z) begin
					errors++;
					$display("%0t: out_z expected %h actual %h", $time, want.out_z, out_word.out_z);
				end
				if (out_word.overflow !== want.overflow) begin
					errors++;
					$display("%0t: overflow expected %b actual %b", $time, want.overflow,
						out_word.overflow);
				end
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WdLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic test_corners();
		int ang [8] = '{0, 32767, -32768, 6434, -6434, 12868, -12868, 25736};
		for (int k = 0; k < 8; k++)
			send_word(make_word(32'h00010000, 32'h00020000, -32'h00030000,
				ang[k], ang[(k + 3) % 8], ang[(k + 5) % 8]));
		send_word(make_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 3217, 3217, 3217));
		send_word(make_word(32'h80000000, 32'h80000000, 32'h80000000, -3217, 3217, -3217));
		send_word(make_word(32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0));
		send_word(make_word(32'h80000000, 0, 32'h7FFFFFFF, 32767, -32768, 32767));
		send_word(make_word(-1, -1, -1, -32768, -32768, -32768));
		send_word(make_word(1, 0, 0, 12868, 0, 0));
		send_word(make_word(0, 1, 0, 0, 12868, 0));
		send_word(make_word(0, 0, 1, 0, 0, 12868));
		send_word(make_word(32'h55555555, 32'hAAAAAAAA, 32'h0000FFFF, 16'h5555, 16'hAAAA,
			16'h7FFF));
	endtask

	task automatic test_random();
		for (int k = 0; k < 1200; k++)
			if ($urandom_range(0, 4) == 0) send_word(random_word(1'b1), 0);
			else send_word(random_word(1'b0));
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_out = 1'b1;
				repeat (150) @(negedge clk);
				hold_out = 1'b0;
			end
			send_burst(120);
		join
		wait_drained();
		send_burst(60);
	endtask

	initial begin
		errors   = 0;
		hold_out = 1'b0;
		idle_cycles = 0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_word  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_corners();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (Latency + 10) @(negedge clk);
		if (errors == 0 && rotated_q.size() == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
